>>> design/assert_macros.svh
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> design/lpmt_pkg.sv
`default_nettype none
package lpmt_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 64;
   localparam int PLEN_W     = 6;
   localparam int CNT_W      = 5;
   localparam int STATUS_W   = 3;
   localparam int KEY_IDX_W  = $clog2(KEY_BITS);

   localparam logic [PLEN_W-1:0] KEY_PLEN = PLEN_W'(KEY_BITS);

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   localparam logic [1:0] MODE_ANY      = 2'd0;
   localparam logic [1:0] MODE_NOEXIST  = 2'd1;
   localparam logic [1:0] MODE_EXIST    = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_POOL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

   localparam logic [CNT_W-1:0] ENTRY_LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic                  command;
      logic [PLEN_W-1:0]     key_prefix_len;
      logic [KEY_BITS-1:0]   key_addr;
      logic [VALUE_BITS-1:0] new_value;
      logic [1:0]            write_mode;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  hit;
      logic [VALUE_BITS-1:0] found_value;
      logic [CNT_W-1:0]      entries_in_use;
   } rsp_type;

   // A queued request together with the front end's verdict on its fields.
   typedef struct packed {
      req_type req;
      logic    bad;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_NULL,
      BK_WR_NEW,
      BK_WR_IM,
      BK_WR_PAR,
      BK_RESP
   } back_state_type;

   // Count of equal leading bits given the XOR of two keys.
   function automatic logic [PLEN_W-1:0] lead_zeros(input logic [KEY_BITS-1:0] d);
      logic [PLEN_W-1:0] n;
      n = KEY_PLEN;
      for (int i = 0; i < KEY_BITS; i++) begin
         if (d[i]) begin
            n = PLEN_W'(KEY_BITS - 1 - i);
         end
      end
      return n;
   endfunction

   // Bit at prefix position pos, counted from the most significant bit.
   function automatic logic key_bit(input logic [KEY_BITS-1:0] k,
                                    input logic [PLEN_W-1:0] pos);
      logic [PLEN_W-1:0] p;
      p = PLEN_W'(KEY_BITS - 1) - pos;
      if (pos >= KEY_PLEN) begin
         return 1'b0;
      end
      return k[p[KEY_IDX_W-1:0]];
   endfunction

endpackage
`default_nettype wire

>>> design/lpm_trie_lookup_update.sv
// Longest-prefix-match trie over IPv4 keys, with lookups and updates.
// The request channel (req_valid, req_ready, req_data) takes one lookup or
// update per request; the response channel (rsp_valid, rsp_ready, rsp_data)
// returns exactly one response per request, in request order.
// A two-entry queue in front of the walker accepts requests while the
// walker is busy, and a response register lets the next request start
// while a finished response still waits for the receiver.
// A lookup walks the trie one visited level after another; an update that
// succeeds takes the same walk plus one to three node writes. With the
// 16-node pool the deepest path has 16 levels. The walk is set by the
// single read port of the node memory, one node per cycle, and the writes
// by its single write port.
// Requests rejected before the walk (bad fields, table full, no free node at
// all) go straight to the response step.
// Reset clears the in-use map, root and entry count, with no sweep of the
// node memory; the entry limit returns to 16.
// If the receiver stalls, one response is held and the walker waits in its
// response step, while the queue keeps taking up to two more requests.
// csr_wr_en writes the entry limit and is meant to be used while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module lpm_trie_lookup_update
   import lpmt_pkg::*;
#(
   parameter int NODE_COUNT = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);

   // Limit on real entries; updates fail with table full at or above it.
   logic [CNT_W-1:0] entry_limit_ff, entry_limit_in;

   logic    job_valid;
   logic    job_pop;
   job_type job_data;

   assign entry_limit_in = csr_wr_en ? csr_wr_data : entry_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_limit_ff <= ENTRY_LIMIT_RESET;
      end else begin
         entry_limit_ff <= entry_limit_in;
      end
   end

   // The front end checks the fields and queues the request.
   lpmt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data)
   );

   // The back end walks the trie, writes nodes and builds the response.
   lpmt_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_limit (entry_limit_ff),
      .job_valid   (job_valid),
      .job_pop     (job_pop),
      .job_data    (job_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // A hit is only reported by a successful lookup.
   `ASSERT_IMPLIES(a_hit_ok, clock, reset, rsp_valid && rsp_data.hit, rsp_data.status == ST_OK)
   // A miss always carries a zero value.
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.found_value == '0)
   // A configuration write lands in the limit register on the next cycle.
   `ASSERT_NEXT(a_cfg_taken, clock, reset, csr_wr_en, entry_limit_ff == $past(csr_wr_data))

endmodule
`default_nettype wire

>>> design/lpmt_front.sv
`default_nettype none
module lpmt_front
   import lpmt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         job_valid,
   input  wire logic    job_pop,
   output job_type      job_data
);

   // Two-entry queue of classified requests.
   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   job_type    job_in;
   logic       push, pop;

   always_comb begin
      job_in.req = req_data;
      job_in.bad = (req_data.key_prefix_len > KEY_PLEN) ||
                   (req_data.command == CMD_UPDATE && req_data.write_mode == MODE_RESERVED);
   end

   assign req_ready = (fill_ff != 2'd2);
   assign job_valid = (fill_ff != 2'd0);
   assign job_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule
`default_nettype wire

>>> design/lpmt_ram.sv
`default_nettype none
module lpmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/lpmt_back.sv
`default_nettype none
module lpmt_back
   import lpmt_pkg::*;
#(
   parameter int NODE_COUNT = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] entry_limit,
   input  wire logic             job_valid,
   output logic                  job_pop,
   input  wire job_type          job_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   localparam int IDX_W = $clog2(NODE_COUNT + 1);
   localparam int AW    = $clog2(NODE_COUNT);
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NODE_COUNT);

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [PLEN_W-1:0]     plen;
      logic                  inter;
      logic [IDX_W-1:0]      left;
      logic [IDX_W-1:0]      right;
      logic [VALUE_BITS-1:0] value;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   back_state_type        state_ff, state_in;
   req_type               job_ff, job_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]      par_idx_ff, par_idx_in;
   node_type              par_rec_ff, par_rec_in;
   logic                  par_null_ff, par_null_in;
   logic                  side_ff, side_in;
   logic [IDX_W-1:0]      nw_ff, nw_in;
   logic [IDX_W-1:0]      im_ff, im_in;
   node_type              new_rec_ff, new_rec_in;
   node_type              im_rec_ff, im_rec_in;
   logic                  need_im_ff, need_im_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] fval_ff, fval_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IDX_W-1:0]      root_ff, root_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NODE_COUNT-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [NODE_W-1:0] rd_data, wr_data;
   node_type          rec;

   logic                  free1_ok, free2_ok;
   logic [IDX_W-1:0]      free1, free2;
   logic [NODE_COUNT-1:0] mask2;

   logic [PLEN_W-1:0] npl, lim, lz, m;
   logic              cont_upd, side_bit, child_null, root_null;
   logic [IDX_W-1:0]  child;

   logic             link_en, use_nw, use_im, drop_cur;
   logic [IDX_W-1:0] link_idx;

   lpmt_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Lowest free node, and the lowest free node besides the one just taken.
   assign mask2 = used_ff | (NODE_COUNT'(1) << nw_ff[AW-1:0]);

   always_comb begin
      free1_ok = 1'b0;
      free1    = NULL_IDX;
      free2_ok = 1'b0;
      free2    = NULL_IDX;
      for (int i = NODE_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free1_ok = 1'b1;
            free1    = IDX_W'(i);
         end
         if (!mask2[i]) begin
            free2_ok = 1'b1;
            free2    = IDX_W'(i);
         end
      end
   end

   // Compare of the node just read against the key.
   always_comb begin
      rec        = node_type'(rd_data);
      npl        = rec.plen;
      lim        = (npl < job_ff.key_prefix_len) ? npl : job_ff.key_prefix_len;
      lz         = lead_zeros(rec.key ^ job_ff.key_addr);
      m          = (lz < lim) ? lz : lim;
      cont_upd   = (npl == m) && (npl != job_ff.key_prefix_len) && (npl != KEY_PLEN);
      side_bit   = key_bit(job_ff.key_addr, npl);
      child      = side_bit ? rec.right : rec.left;
      child_null = (child >= NULL_IDX);
      root_null  = (root_ff >= NULL_IDX);
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cur_in       = cur_ff;
      par_idx_in   = par_idx_ff;
      par_rec_in   = par_rec_ff;
      par_null_in  = par_null_ff;
      side_in      = side_ff;
      nw_in        = nw_ff;
      im_in        = im_ff;
      new_rec_in   = new_rec_ff;
      im_rec_in    = im_rec_ff;
      need_im_in   = need_im_ff;
      found_in     = found_ff;
      fval_in      = fval_ff;
      status_in    = status_ff;
      root_in      = root_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = nw_ff[AW-1:0];
      wr_data      = new_rec_ff;
      link_en      = 1'b0;
      link_idx     = nw_ff;
      use_nw       = 1'b0;
      use_im       = 1'b0;
      drop_cur     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // The new entry's record; children are filled in per case below.
      new_rec_in.key   = job_ff.key_addr;
      new_rec_in.plen  = job_ff.key_prefix_len;
      new_rec_in.inter = 1'b0;
      new_rec_in.value = job_ff.new_value;

      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop     = 1'b1;
               job_in      = job_data.req;
               found_in    = 1'b0;
               fval_in     = '0;
               status_in   = ST_OK;
               par_null_in = 1'b1;
               side_in     = 1'b0;
               need_im_in  = 1'b0;
               if (job_data.bad) begin
                  status_in = ST_INVALID;
                  state_in  = BK_RESP;
               end else if (job_data.req.command == CMD_LOOKUP) begin
                  if (root_null) begin
                     state_in = BK_RESP;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = root_ff[AW-1:0];
                     cur_in   = root_ff;
                     state_in = BK_WALK;
                  end
               end else if (count_ff >= entry_limit) begin
                  status_in = ST_FULL;
                  state_in  = BK_RESP;
               end else if (!free1_ok) begin
                  status_in = ST_POOL;
                  state_in  = BK_RESP;
               end else begin
                  nw_in = free1;
                  if (root_null) begin
                     state_in = BK_NULL;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = root_ff[AW-1:0];
                     cur_in   = root_ff;
                     state_in = BK_WALK;
                  end
               end
            end
         end

         BK_WALK: begin
            if (job_ff.command == CMD_LOOKUP) begin
               if (m == KEY_PLEN) begin
                  found_in = 1'b1;
                  fval_in  = rec.value;
                  state_in = BK_RESP;
               end else if (m < npl) begin
                  state_in = BK_RESP;
               end else begin
                  if (!rec.inter) begin
                     found_in = 1'b1;
                     fval_in  = rec.value;
                  end
                  if (child_null) begin
                     state_in = BK_RESP;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = child[AW-1:0];
                     cur_in  = child;
                  end
               end
            end else if (cont_upd) begin
               par_idx_in  = cur_ff;
               par_rec_in  = rec;
               par_null_in = 1'b0;
               side_in     = side_bit;
               if (child_null) begin
                  state_in = BK_NULL;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = child[AW-1:0];
                  cur_in  = child;
               end
            end else if (npl == m) begin
               // Exact prefix already present: replace the node, unless the write mode forbids it.
               if (!rec.inter && job_ff.write_mode == MODE_NOEXIST) begin
                  status_in = ST_EXISTS;
                  state_in  = BK_RESP;
               end else if (rec.inter && job_ff.write_mode == MODE_EXIST) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = BK_RESP;
               end else begin
                  new_rec_in.left  = rec.left;
                  new_rec_in.right = rec.right;
                  link_en          = 1'b1;
                  use_nw           = 1'b1;
                  drop_cur         = 1'b1;
                  if (rec.inter) begin
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = BK_WR_NEW;
               end
            end else if (job_ff.write_mode == MODE_EXIST) begin
               status_in = ST_NOT_FOUND;
               state_in  = BK_RESP;
            end else if (m == job_ff.key_prefix_len) begin
               // The new prefix is shorter and becomes the node's ancestor.
               if (key_bit(rec.key, m)) begin
                  new_rec_in.left  = NULL_IDX;
                  new_rec_in.right = cur_ff;
               end else begin
                  new_rec_in.left  = cur_ff;
                  new_rec_in.right = NULL_IDX;
               end
               link_en  = 1'b1;
               use_nw   = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = BK_WR_NEW;
            end else if (!free2_ok) begin
               status_in = ST_POOL;
               state_in  = BK_RESP;
            end else begin
               // Paths diverge: an intermediate node takes both.
               im_in           = free2;
               im_rec_in.key   = rec.key;
               im_rec_in.plen  = m;
               im_rec_in.inter = 1'b1;
               im_rec_in.value = '0;
               if (key_bit(job_ff.key_addr, m)) begin
                  im_rec_in.left  = cur_ff;
                  im_rec_in.right = nw_ff;
               end else begin
                  im_rec_in.left  = nw_ff;
                  im_rec_in.right = cur_ff;
               end
               new_rec_in.left  = NULL_IDX;
               new_rec_in.right = NULL_IDX;
               link_en          = 1'b1;
               link_idx         = free2;
               use_nw           = 1'b1;
               use_im           = 1'b1;
               need_im_in       = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               state_in         = BK_WR_NEW;
            end
         end

         BK_NULL: begin
            if (job_ff.write_mode == MODE_EXIST) begin
               status_in = ST_NOT_FOUND;
               state_in  = BK_RESP;
            end else begin
               new_rec_in.left  = NULL_IDX;
               new_rec_in.right = NULL_IDX;
               link_en          = 1'b1;
               use_nw           = 1'b1;
               count_in         = count_ff + CNT_W'(1);
               state_in         = BK_WR_NEW;
            end
         end

         BK_WR_NEW: begin
            wr_en = 1'b1;
            if (need_im_ff) begin
               state_in = BK_WR_IM;
            end else if (par_null_ff) begin
               state_in = BK_RESP;
            end else begin
               state_in = BK_WR_PAR;
            end
         end

         BK_WR_IM: begin
            wr_en    = 1'b1;
            wr_addr  = im_ff[AW-1:0];
            wr_data  = im_rec_ff;
            state_in = par_null_ff ? BK_RESP : BK_WR_PAR;
         end

         BK_WR_PAR: begin
            wr_en    = 1'b1;
            wr_addr  = par_idx_ff[AW-1:0];
            wr_data  = par_rec_ff;
            state_in = BK_RESP;
         end

         BK_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.hit            = found_ff;
               rsp_data_in.found_value    = fval_ff;
               rsp_data_in.entries_in_use = count_ff;
               state_in                   = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Hook the new subtree under its parent, or make it the root.
      if (link_en) begin
         if (par_null_ff) begin
            root_in = link_idx;
         end else if (side_ff) begin
            par_rec_in.right = link_idx;
         end else begin
            par_rec_in.left = link_idx;
         end
      end
      if (drop_cur) begin
         used_in[cur_ff[AW-1:0]] = 1'b0;
      end
      if (use_nw) begin
         used_in[nw_ff[AW-1:0]] = 1'b1;
      end
      if (use_im) begin
         used_in[free2[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         root_ff      <= NULL_IDX;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      cur_ff      <= cur_in;
      par_idx_ff  <= par_idx_in;
      par_rec_ff  <= par_rec_in;
      par_null_ff <= par_null_in;
      side_ff     <= side_in;
      nw_ff       <= nw_in;
      im_ff       <= im_in;
      new_rec_ff  <= new_rec_in;
      im_rec_ff   <= im_rec_in;
      need_im_ff  <= need_im_in;
      found_ff    <= found_in;
      fval_ff     <= fval_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> test/lpm_trie_lookup_update_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module lpm_trie_lookup_update_checker
   import lpmt_pkg::*;
#(
   parameter int NODE_COUNT = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire req_type          req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rsp_type          rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    rsp_count
);

   localparam int NIL = NODE_COUNT;

   // Mirror of the trie held in the node pool.
   logic [KEY_BITS-1:0]   t_key   [NODE_COUNT];
   int                    t_plen  [NODE_COUNT];
   bit                    t_inter [NODE_COUNT];
   int                    t_left  [NODE_COUNT];
   int                    t_right [NODE_COUNT];
   logic [VALUE_BITS-1:0] t_val   [NODE_COUNT];
   bit                    t_used  [NODE_COUNT];
   int                    t_root;
   int                    t_count;
   int                    t_limit;

   rsp_type expected_rsps[$];

   function automatic int bit_at(logic [KEY_BITS-1:0] k, int pos);
      if (pos >= KEY_BITS) begin
         return 0;
      end
      return int'(k[KEY_BITS-1-pos]);
   endfunction

   function automatic int common_len(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b,
                                     int lim);
      int n;
      n = 0;
      while (n < KEY_BITS && bit_at(a ^ b, n) == 0) begin
         n++;
      end
      return n < lim ? n : lim;
   endfunction

   function automatic int take_node();
      for (int i = 0; i < NODE_COUNT; i++) begin
         if (!t_used[i]) begin
            t_used[i] = 1;
            t_left[i] = NIL;
            t_right[i] = NIL;
            t_inter[i] = 0;
            t_val[i] = '0;
            return i;
         end
      end
      return NIL;
   endfunction

   function automatic int child(int n, int side);
      int c;
      c = side ? t_right[n] : t_left[n];
      return c < NODE_COUNT ? c : NIL;
   endfunction

   function automatic void link(int parent, int side, int c);
      if (parent >= NODE_COUNT) begin
         t_root = c;
      end else if (side) begin
         t_right[parent] = c;
      end else begin
         t_left[parent] = c;
      end
   endfunction

   function automatic logic [STATUS_W-1:0] apply_update(req_type r);
      int nw, im, node, parent, side, m, steps, npl, kpl;
      bit real_n;
      kpl = int'(r.key_prefix_len);
      parent = NIL;
      side = 0;
      m = 0;
      steps = 0;
      if (r.write_mode == MODE_RESERVED || kpl > KEY_BITS) begin
         return ST_INVALID;
      end
      if (t_count >= t_limit) begin
         return ST_FULL;
      end
      nw = take_node();
      if (nw == NIL) begin
         return ST_POOL;
      end
      t_key[nw] = r.key_addr;
      t_plen[nw] = kpl;
      t_val[nw] = r.new_value;
      node = t_root;
      while (node != NIL && steps <= NODE_COUNT) begin
         npl = t_plen[node];
         m = common_len(t_key[node], r.key_addr, npl < kpl ? npl : kpl);
         if (npl != m || npl == kpl || npl == KEY_BITS) begin
            break;
         end
         side = bit_at(r.key_addr, npl);
         parent = node;
         node = child(node, side);
         steps++;
      end
      if (node == NIL) begin
         if (r.write_mode == MODE_EXIST) begin
            t_used[nw] = 0;
            return ST_NOT_FOUND;
         end
         link(parent, side, nw);
         t_count++;
         return ST_OK;
      end
      if (t_plen[node] == m) begin
         real_n = !t_inter[node];
         if (real_n && r.write_mode == MODE_NOEXIST) begin
            t_used[nw] = 0;
            return ST_EXISTS;
         end
         if (!real_n && r.write_mode == MODE_EXIST) begin
            t_used[nw] = 0;
            return ST_NOT_FOUND;
         end
         t_left[nw] = t_left[node];
         t_right[nw] = t_right[node];
         link(parent, side, nw);
         t_used[node] = 0;
         if (!real_n) begin
            t_count++;
         end
         return ST_OK;
      end
      if (r.write_mode == MODE_EXIST) begin
         t_used[nw] = 0;
         return ST_NOT_FOUND;
      end
      if (m == kpl) begin
         if (bit_at(t_key[node], m)) begin
            t_right[nw] = node;
         end else begin
            t_left[nw] = node;
         end
         link(parent, side, nw);
         t_count++;
         return ST_OK;
      end
      im = take_node();
      if (im == NIL) begin
         t_used[nw] = 0;
         return ST_POOL;
      end
      t_plen[im] = m;
      t_inter[im] = 1;
      t_key[im] = t_key[node];
      if (bit_at(r.key_addr, m)) begin
         t_left[im] = node;
         t_right[im] = nw;
      end else begin
         t_left[im] = nw;
         t_right[im] = node;
      end
      link(parent, side, im);
      t_count++;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int n, found, steps, npl, kpl, m;
      o = '0;
      kpl = int'(r.key_prefix_len);
      if (r.command == CMD_UPDATE) begin
         o.status = apply_update(r);
      end else if (kpl > KEY_BITS) begin
         o.status = ST_INVALID;
      end else begin
         found = NIL;
         steps = 0;
         n = t_root;
         while (n != NIL && steps <= NODE_COUNT) begin
            npl = t_plen[n];
            m = common_len(t_key[n], r.key_addr, npl < kpl ? npl : kpl);
            if (m == KEY_BITS) begin
               found = n;
               break;
            end
            if (m < npl) begin
               break;
            end
            if (!t_inter[n]) begin
               found = n;
            end
            n = child(n, bit_at(r.key_addr, npl));
            steps++;
         end
         if (found != NIL) begin
            o.hit = 1'b1;
            o.found_value = t_val[found];
         end
      end
      o.entries_in_use = CNT_W'(t_count);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NODE_COUNT; i++) begin
            t_used[i] = 0;
         end
         t_root = NIL;
         t_count = 0;
         t_limit = 16;
         expected_rsps.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with nothing expected, actual %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status || rsp_data.hit !== want.hit ||
                   rsp_data.found_value !== want.found_value ||
                   rsp_data.entries_in_use !== want.entries_in_use) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_rsp(req_data));
         end
         if (csr_wr_en) begin
            t_limit = int'(csr_wr_data);
         end
      end
      pending_count <= expected_rsps.size();
   end

endmodule
`default_nettype wire

>>> test/lpm_trie_lookup_update_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module lpm_trie_lookup_update_tb;
   import lpmt_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;
   int               fail_count;
   int               pending_count;
   int               rsp_count;
   int               sent_count;
   int               idle_cycles;
   bit               sending_done;

   // A small pool of prefixes, so that updates and lookups keep landing on
   // the same parts of the trie and splits, replacements and misses all occur.
   logic [KEY_BITS-1:0] key_pool [8];

   lpm_trie_lookup_update #(.NODE_COUNT(16)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   lpm_trie_lookup_update_checker #(.NODE_COUNT(16)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // The receiver stalls in runs: a phase counter picks a new stall rate, from
   // none up to heavy back-pressure of 75 percent, for each stretch.
   int stall_pct;
   int phase_cnt;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         phase_cnt <= 0;
         stall_pct <= 0;
      end else begin
         phase_cnt <= phase_cnt + 1;
         if (phase_cnt % 64 == 0) begin
            stall_pct <= $urandom_range(0, 3) * 25;
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: a long stretch with no request or response accepted ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!sending_done || pending_count != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("lpm_trie_lookup_update_tb: errors");
            $finish;
         end
      end
   end

   // Present one request and hold it until it is accepted. Valid stays high
   // afterwards, so a following request can go out on the next cycle; the
   // caller drops it when a gap begins.
   task automatic send_req(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_count++;
      @(negedge clock);
   endtask

   // Wait at the falling edge until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0 || rsp_valid) begin
         @(negedge clock);
      end
      repeat (50) @(negedge clock);
   endtask

   task automatic write_limit(logic [CNT_W-1:0] lim);
      csr_wr_en <= 1'b1;
      csr_wr_data <= lim;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type make_req(logic cmd, int plen, logic [KEY_BITS-1:0] addr,
                                        logic [1:0] mode);
      req_type r;
      r.command = cmd;
      r.key_prefix_len = PLEN_W'(plen);
      r.key_addr = addr;
      r.new_value = {$urandom(), $urandom()};
      r.write_mode = mode;
      return r;
   endfunction

   // Mostly well-formed requests on pooled prefixes; a few wild ones.
   function automatic req_type random_req();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r = make_req(1'($urandom_range(0, 1)), $urandom_range(0, 32),
                   key_pool[3'($urandom_range(0, 7))] ^ ($urandom_range(0, 3) == 0 ?
                   $urandom() : 32'h0), 2'($urandom_range(0, 2)));
      if (pick < 5) begin
         r.key_prefix_len = PLEN_W'($urandom_range(33, 63));
      end else if (pick < 9) begin
         r.write_mode = MODE_RESERVED;
      end else if (pick < 12) begin
         r.key_addr = $urandom();
      end
      return r;
   endfunction

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            send_req(random_req());
            burst--;
            count--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   endtask

   initial begin
      logic [7:0] settings [5];
      settings = '{8'd16, 8'd0, 8'd3, 8'd10, 8'd16};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      sent_count = 0;
      sending_done = 1'b0;
      for (int i = 0; i < 8; i++) begin
         key_pool[i] = $urandom();
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening: empty-table lookups, bad fields, inserts with
      // splits and ancestors, each write mode, a default route and a /32.
      send_req(make_req(CMD_LOOKUP, 0, 32'h0, MODE_ANY));
      send_req(make_req(CMD_LOOKUP, 63, 32'hFFFF_FFFF, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 8, 32'h0A00_0000, MODE_RESERVED));
      send_req(make_req(CMD_UPDATE, 33, 32'h0A00_0000, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 8, 32'h0A00_0000, MODE_EXIST));
      send_req(make_req(CMD_UPDATE, 8, 32'h0A00_0000, MODE_NOEXIST));
      send_req(make_req(CMD_UPDATE, 8, 32'h0AFF_FFFF, MODE_NOEXIST));
      send_req(make_req(CMD_UPDATE, 8, 32'h0A00_0000, MODE_EXIST));
      send_req(make_req(CMD_UPDATE, 16, 32'h0A01_0000, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 16, 32'h0A02_0000, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 24, 32'h0B02_0300, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 0, 32'hFFFF_FFFF, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 32, 32'hFFFF_FFFF, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 32, 32'h0000_0000, MODE_ANY));
      send_req(make_req(CMD_UPDATE, 14, 32'h0A00_0000, MODE_EXIST));
      send_req(make_req(CMD_UPDATE, 14, 32'h0A00_0000, MODE_ANY));
      send_req(make_req(CMD_LOOKUP, 32, 32'h0A01_0203, MODE_ANY));
      send_req(make_req(CMD_LOOKUP, 32, 32'h0A03_0000, MODE_ANY));
      send_req(make_req(CMD_LOOKUP, 32, 32'hFFFF_FFFF, MODE_ANY));
      send_req(make_req(CMD_LOOKUP, 32, 32'h7000_0000, MODE_RESERVED));
      send_req(make_req(CMD_LOOKUP, 4, 32'h0A00_0000, MODE_ANY));
      drain();

      // Random phases under several table limits, extremes included. Each
      // phase starts from a table that may already be full, so pool-empty
      // and table-full answers both turn up.
      foreach (settings[i]) begin
         write_limit(CNT_W'(settings[i]));
         random_phase(275);
         drain();
      end

      sending_done = 1'b1;
      drain();
      $display("Covered %0d requests and %0d responses over five table limits,",
               sent_count, rsp_count);
      $display("including splits, replacements, mode rejects and a full pool.");
      if (fail_count == 0) begin
         $display("lpm_trie_lookup_update_tb: clean");
      end else begin
         $display("lpm_trie_lookup_update_tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
